// ----- design/irc_tok_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and character codes for the IRC message tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChNul   = 8'h00;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PhStart  = 8'b0000_0001,
    PhSource = 8'b0000_0010,
    PhFind   = 8'b0000_0100,
    PhWord   = 8'b0000_1000,
    PhColon  = 8'b0001_0000,
    PhTrail  = 8'b0010_0000,
    PhEol    = 8'b0100_0000,
    PhDone   = 8'b1000_0000
  } phase_e;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [8:0] byte_position;
    logic       arg_begins;
    logic [3:0] arg_slot;
    logic [4:0] args_found;
    logic       parse_done;
    logic [9:0] consumed_length;
  } res_t;

endpackage
`default_nettype wire

// ----- design/irc_message_tokenizer_unit.sv -----
`default_nettype none
// A result beat is registered into the result register, or into the skid
// register while a beat waits there. Throughput: one byte per cycle while
// in_ready_o is high; the phase update is a single pass of logic between
// the accepted byte and the result register. A two-entry output (result
// register plus skid register) keeps in_ready_o high while one result waits.
// Reset gives start phase, zero arguments, index zero, empty output entries.
// ----------------------------------------------------------------------------
// irc_message_tokenizer_unit
// Streaming tokenizer for one IRC line: skips an optional source prefix,
// marks argument starts, zeroes word-ending spaces and line-ending bytes,
// and reports the consumed length once past the line ending or at the last byte.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_unit
  import irc_tok_pkg::*;
#(
  parameter int MAX_ARGS     = 16,
  parameter int BUFFER_BYTES = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input beat
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  // result beat
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [8:0]      byte_position_o,
  output logic            arg_begins_o,
  output logic [3:0]      arg_slot_o,
  output logic [4:0]      args_found_o,
  output logic            parse_done_o,
  output logic [9:0]      consumed_length_o
);

  localparam int CW = $clog2(MAX_ARGS + 1);   // argument counter
  localparam int IW = $clog2(BUFFER_BYTES);   // byte index

  // Parser state
  phase_e          phase_q, phase_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   idx_q, idx_d;

  // Output entries
  logic  out_vld_q, skid_vld_q;
  res_t  out_q, skid_q;
  res_t  res;

  logic  in_fire, out_fire;

  // Per-byte decode
  logic            last, eol, was_done, can_note;
  phase_e          phase_nxt;
  logic [CW-1:0]   cnt_nxt;
  logic [7:0]      ob;
  logic            begins, done, len_at_pos, len_plus1;
  logic [IW:0]     len_full;
  logic [IW+10:0]  len_wide;
  logic [IW+8:0]   pos_wide;
  logic [CW+3:0]   slot_wide;
  logic [CW+4:0]   found_wide;

  assign in_ready_o = !skid_vld_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  assign last     = last_byte_i || (idx_q == IW'(BUFFER_BYTES - 1));
  assign eol      = (data_byte_i == ChCr) || (data_byte_i == ChLf);
  assign was_done = (phase_q == PhDone);
  assign can_note = (cnt_q < CW'(MAX_ARGS));

  always_comb begin
    phase_nxt  = phase_q;
    cnt_nxt    = cnt_q;
    ob         = data_byte_i;
    begins     = 1'b0;
    done       = 1'b0;
    len_at_pos = 1'b0;
    len_plus1  = 1'b0;

    unique case (phase_q)
      PhStart, PhFind: begin
        if (eol) begin
          ob        = ChNul;
          phase_nxt = PhEol;
        end else if (data_byte_i == ChSp) begin
          phase_nxt = phase_q;
        end else if (data_byte_i == ChColon) begin
          phase_nxt = (phase_q == PhStart) ? PhSource : PhColon;
        end else begin
          begins    = can_note;
          phase_nxt = PhWord;
        end
      end
      PhSource: begin
        if (eol) begin
          ob        = ChNul;
          phase_nxt = PhEol;
        end else if (data_byte_i == ChSp) begin
          phase_nxt = PhFind;
        end
      end
      PhWord: begin
        if (eol) begin
          ob        = ChNul;
          phase_nxt = PhEol;
        end else if (data_byte_i == ChSp) begin
          ob        = ChNul;
          phase_nxt = PhFind;
        end
      end
      PhColon: begin
        // trailing argument starts here, even when empty
        begins = can_note;
        if (eol) begin
          ob        = ChNul;
          phase_nxt = PhEol;
        end else begin
          phase_nxt = PhTrail;
        end
      end
      PhTrail: begin
        if (eol) begin
          ob        = ChNul;
          phase_nxt = PhEol;
        end
      end
      PhEol: begin
        if (eol) begin
          ob = ChNul;
        end else begin
          done       = 1'b1;
          len_at_pos = 1'b1;
          phase_nxt  = PhDone;
        end
      end
      default: ;  // done: bytes pass unchanged
    endcase

    if (begins) begin
      cnt_nxt = cnt_q + CW'(1);
    end

    // last byte or buffer end decides the outcome if nothing else did
    if (last && !was_done && !done) begin
      done      = 1'b1;
      len_plus1 = (phase_nxt == PhEol);
    end
  end

  always_comb begin
    len_full = '0;
    if (len_at_pos) begin
      len_full = (IW+1)'(idx_q);
    end else if (len_plus1) begin
      len_full = (IW+1)'(idx_q) + (IW+1)'(1);
    end
    len_wide   = (IW+11)'(len_full);
    pos_wide   = (IW+9)'(idx_q);
    slot_wide  = (CW+4)'(cnt_q);
    found_wide = (CW+5)'(cnt_nxt);

    res.out_byte        = ob;
    res.byte_position   = pos_wide[8:0];
    res.arg_begins      = begins;
    res.arg_slot        = begins ? slot_wide[3:0] : 4'd0;
    res.args_found      = found_wide[4:0];
    res.parse_done      = done;
    res.consumed_length = len_wide[9:0];
  end

  // Next parser state; a last beat returns the parser state to its reset values.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    if (in_fire) begin
      if (last) begin
        phase_d = PhStart;
        cnt_d   = '0;
        idx_d   = '0;
      end else begin
        phase_d = phase_nxt;
        cnt_d   = cnt_nxt;
        idx_d   = idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // Result register plus skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_fire) begin
        out_vld_q  <= skid_vld_q || in_fire;
        skid_vld_q <= 1'b0;
      end else if (in_fire) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_fire) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_byte_o        = out_q.out_byte;
  assign byte_position_o   = out_q.byte_position;
  assign arg_begins_o      = out_q.arg_begins;
  assign arg_slot_o        = out_q.arg_slot;
  assign args_found_o      = out_q.args_found;
  assign parse_done_o      = out_q.parse_done;
  assign consumed_length_o = out_q.consumed_length;

endmodule
`default_nettype wire
